// File: rtl/v3a_pkg.sv
// Shared types, constants and helpers for the three-dimensional vector ALU.
`timescale 1ns / 1ps
package v3a_pkg;

  // Fractional bits of the fixed-point format (8 to 24)
  localparam int FracBits   = 16;
  // Result bits of the square root (64-bit radicand, one root bit per stage)
  localparam int SqrtStages = 32;
  // Quotient bits: 32-bit magnitude shifted up by the fraction
  localparam int QuoW       = 32 + FracBits;
  // Width that holds any product sum before scaling
  localparam int WideW      = 66;
  // Queue between front and back; must be a power of two
  localparam int FifoDepth  = 4;
  localparam int PtrW       = $clog2(FifoDepth);

  typedef logic signed [31:0]      fix_t;
  typedef logic signed [WideW-1:0] wide_t;
  typedef fix_t [2:0]              vec_t;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DIV   = 4'd3,
    OP_EQ    = 4'd4,
    OP_DOT   = 4'd5,
    OP_CROSS = 4'd6,
    OP_MAG   = 4'd7,
    OP_NORM  = 4'd8,
    OP_SRES  = 4'd9,
    OP_VRES  = 4'd10,
    OP_PERP  = 4'd11
  } op_e;

  // Classified transaction handed from front to back
  typedef struct packed {
    op_e  op;
    logic err;
    vec_t a;
    vec_t b;
    fix_t s;
    vec_t v;   // vector whose magnitude is taken
  } item_t;

  typedef struct packed {
    vec_t v;
    fix_t s;
    logic eq;
    logic err;
  } res_t;

  typedef struct packed {
    item_t it;
    res_t  res;
  } ctx_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic fix_t sat32(wide_t x);
    fix_t r;
    if ((&x[WideW-1:31]) || (~|x[WideW-1:31])) begin
      r = x[31:0];
    end else if (x[WideW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// File: rtl/v3a_front.sv
// Front end: registers an incoming transaction and classifies it.
`timescale 1ns / 1ps
module v3a_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [3:0]            op_i,
  input  logic signed [31:0]    a_x_i,
  input  logic signed [31:0]    a_y_i,
  input  logic signed [31:0]    a_z_i,
  input  logic signed [31:0]    b_x_i,
  input  logic signed [31:0]    b_y_i,
  input  logic signed [31:0]    b_z_i,
  input  logic signed [31:0]    scalar_in_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output v3a_pkg::item_t        item_o
);

  logic           vld_q;
  v3a_pkg::item_t item_q, item_d;
  logic           a_zero, b_zero;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  // Classify: flag bad ops, zero divisors and zero vectors; pick the vector to measure
  always_comb begin
    a_zero      = (a_x_i == '0) && (a_y_i == '0) && (a_z_i == '0);
    b_zero      = (b_x_i == '0) && (b_y_i == '0) && (b_z_i == '0);
    item_d.op   = v3a_pkg::op_e'(op_i);
    item_d.a    = {a_z_i, a_y_i, a_x_i};
    item_d.b    = {b_z_i, b_y_i, b_x_i};
    item_d.s    = scalar_in_i;
    item_d.v    = {a_z_i, a_y_i, a_x_i};
    item_d.err  = 1'b0;
    case (v3a_pkg::op_e'(op_i))
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_SCALE, v3a_pkg::OP_EQ,
      v3a_pkg::OP_DOT, v3a_pkg::OP_CROSS, v3a_pkg::OP_MAG: begin
        item_d.err = 1'b0;
      end
      v3a_pkg::OP_DIV: begin
        item_d.err = (scalar_in_i == '0);
      end
      v3a_pkg::OP_NORM: begin
        item_d.err = a_zero;
      end
      v3a_pkg::OP_SRES, v3a_pkg::OP_VRES, v3a_pkg::OP_PERP: begin
        item_d.err = b_zero;
        item_d.v   = {b_z_i, b_y_i, b_x_i};
      end
      default: begin
        item_d.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Capture payload on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// File: rtl/v3a_fifo.sv
// Short queue that decouples the front end from the execution pipeline.
`timescale 1ns / 1ps
module v3a_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  v3a_pkg::item_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output v3a_pkg::item_t pop_data_o
);

  logic [v3a_pkg::PtrW-1:0] wr_q, rd_q;
  logic [v3a_pkg::PtrW:0]   cnt_q;
  v3a_pkg::item_t           mem_q [v3a_pkg::FifoDepth];
  logic                     push, pop;

  assign push_ready_o = (cnt_q != (v3a_pkg::PtrW + 1)'(v3a_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/v3a_sqrt.sv
// Pipelined integer square root: one root bit per stage over a 64-bit radicand.
`timescale 1ns / 1ps
module v3a_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  localparam int N = v3a_pkg::SqrtStages;

  logic [63:0] n_q    [N];
  logic [31:0] root_q [N];
  logic [33:0] rem_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [63:0] n_in;
    logic [31:0] root_in;
    logic [33:0] rem_in;
    logic [35:0] rem_sh, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign n_in    = rad_i;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
    end

    // Bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in, n_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= {n_in[61:0], 2'b00};
        root_q[k] <= {root_in[30:0], ge};
        rem_q[k]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

// File: rtl/v3a_div.sv
// Pipelined restoring divider: (num << FracBits) / den on magnitudes, one bit per stage.
`timescale 1ns / 1ps
module v3a_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [31:0]                num_i,
  input  logic [31:0]                den_i,
  output logic [v3a_pkg::QuoW-1:0]   quo_o
);

  localparam int QW = v3a_pkg::QuoW;

  logic [QW-1:0] dvd_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [31:0]   rem_q [QW];
  logic [31:0]   den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0] dvd_in, quo_in;
    logic [31:0]   rem_in, den_in;
    logic [32:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign dvd_in = {num_i, {v3a_pkg::FracBits{1'b0}}};
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Shift in the next dividend bit and subtract when it fits
    assign rem_sh = {rem_in, dvd_in[QW-1]};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[k] <= {dvd_in[QW-2:0], 1'b0};
        quo_q[k] <= {quo_in[QW-2:0], ge};
        rem_q[k] <= ge ? 32'(rem_sh - {1'b0, den_in}) : rem_sh[31:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// File: rtl/v3a_back.sv
// Execution pipeline: products, sums, square root, division and resolutes.
`timescale 1ns / 1ps
module v3a_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  v3a_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output v3a_pkg::res_t  res_o
);

  localparam int SqN = v3a_pkg::SqrtStages;
  localparam int DvN = v3a_pkg::QuoW;

  logic en;

  // Multiply stage
  v3a_pkg::fix_t  mx [6];
  v3a_pkg::fix_t  my [6];
  logic signed [63:0] p_d [6];
  logic               m_vld_q;
  v3a_pkg::item_t     m_it_q;
  logic signed [63:0] m_p_q [6];

  // Add stage
  v3a_pkg::wide_t     w_d [3];
  v3a_pkg::wide_t     sum_d;
  logic               w_vld_q;
  v3a_pkg::item_t     w_it_q;
  v3a_pkg::wide_t     w_q [3];
  v3a_pkg::wide_t     sum_q;

  // Square root section
  v3a_pkg::ctx_t      sq_ctx_d;
  logic [SqN-1:0]     sq_vld_q;
  v3a_pkg::ctx_t      sq_ctx_q [SqN];
  logic [31:0]        root;

  // Divide section
  v3a_pkg::ctx_t      dv_ctx_d;
  logic               is_div;
  logic [31:0]        den;
  logic [31:0]        num [3];
  logic [DvN-1:0]     dv_vld_q;
  v3a_pkg::ctx_t      dv_ctx_q [DvN];
  logic [DvN-1:0]     quo [3];

  // Resolute section
  v3a_pkg::ctx_t      dv_out;
  v3a_pkg::fix_t      u_d [3];
  logic               u_neg;
  v3a_pkg::wide_t     u_wq;
  logic               u_vld_q;
  v3a_pkg::ctx_t      u_ctx_q;
  v3a_pkg::fix_t      u_q [3];

  logic               d1_vld_q;
  v3a_pkg::ctx_t      d1_ctx_q;
  v3a_pkg::fix_t      d1_u_q [3];
  logic signed [63:0] d1_p_q [3];

  logic               d2_vld_q;
  v3a_pkg::ctx_t      d2_ctx_q;
  v3a_pkg::fix_t      d2_u_q [3];
  v3a_pkg::wide_t     d2_sum_q;

  logic               d3_vld_q;
  v3a_pkg::ctx_t      d3_ctx_q;
  v3a_pkg::fix_t      d3_u_q [3];
  v3a_pkg::fix_t      d3_sr_q;

  logic               r1_vld_q;
  v3a_pkg::ctx_t      r1_ctx_q;
  v3a_pkg::fix_t      r1_u_q [3];
  v3a_pkg::fix_t      r1_sr_q;
  logic signed [63:0] r1_p_q [3];

  logic               r2_vld_q;
  v3a_pkg::ctx_t      r2_ctx_q;
  v3a_pkg::fix_t      r2_u_q [3];
  v3a_pkg::fix_t      r2_sr_q;
  v3a_pkg::fix_t      r2_vr_q [3];

  v3a_pkg::res_t      res_d;
  logic               out_vld_q;
  v3a_pkg::res_t      res_q;

  // Whole pipeline advances unless a finished result is stuck at the output
  assign en           = !out_vld_q || out_ready_i;
  assign item_ready_o = en;
  assign out_valid_o  = out_vld_q;
  assign res_o        = res_q;

  // Select multiplier operands by opcode
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mx[i] = '0;
      my[i] = '0;
    end
    case (item_i.op)
      v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = item_i.a[i];
          my[i] = item_i.s;
        end
      end
      v3a_pkg::OP_CROSS: begin
        mx[0] = item_i.a[1]; my[0] = item_i.b[2];
        mx[1] = item_i.a[2]; my[1] = item_i.b[1];
        mx[2] = item_i.a[2]; my[2] = item_i.b[0];
        mx[3] = item_i.a[0]; my[3] = item_i.b[2];
        mx[4] = item_i.a[0]; my[4] = item_i.b[1];
        mx[5] = item_i.a[1]; my[5] = item_i.b[0];
      end
      v3a_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = item_i.a[i];
          my[i] = item_i.b[i];
        end
      end
      v3a_pkg::OP_MAG, v3a_pkg::OP_NORM, v3a_pkg::OP_SRES,
      v3a_pkg::OP_VRES, v3a_pkg::OP_PERP: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = item_i.v[i];
          my[i] = item_i.v[i];
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      p_d[i] = 64'(mx[i]) * 64'(my[i]);
    end
  end

  // Combine products: cross differences, or the three-term sum
  always_comb begin
    if (m_it_q.op == v3a_pkg::OP_CROSS) begin
      w_d[0] = v3a_pkg::wide_t'(m_p_q[0]) - v3a_pkg::wide_t'(m_p_q[1]);
      w_d[1] = v3a_pkg::wide_t'(m_p_q[2]) - v3a_pkg::wide_t'(m_p_q[3]);
      w_d[2] = v3a_pkg::wide_t'(m_p_q[4]) - v3a_pkg::wide_t'(m_p_q[5]);
    end else begin
      for (int i = 0; i < 3; i++) begin
        w_d[i] = v3a_pkg::wide_t'(m_p_q[i]);
      end
    end
    sum_d = v3a_pkg::wide_t'(m_p_q[0]) + v3a_pkg::wide_t'(m_p_q[1])
          + v3a_pkg::wide_t'(m_p_q[2]);
  end

  // Form the results of the short operations
  always_comb begin
    sq_ctx_d.it  = w_it_q;
    sq_ctx_d.res = '0;
    case (w_it_q.op)
      v3a_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          sq_ctx_d.res.v[i] = v3a_pkg::sat32(v3a_pkg::wide_t'($signed(w_it_q.a[i]))
                                           + v3a_pkg::wide_t'($signed(w_it_q.b[i])));
        end
      end
      v3a_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          sq_ctx_d.res.v[i] = v3a_pkg::sat32(v3a_pkg::wide_t'($signed(w_it_q.a[i]))
                                           - v3a_pkg::wide_t'($signed(w_it_q.b[i])));
        end
      end
      v3a_pkg::OP_SCALE, v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          sq_ctx_d.res.v[i] = v3a_pkg::sat32(w_q[i] >>> v3a_pkg::FracBits);
        end
      end
      v3a_pkg::OP_DOT: begin
        sq_ctx_d.res.s = v3a_pkg::sat32(sum_q >>> v3a_pkg::FracBits);
      end
      v3a_pkg::OP_EQ: begin
        sq_ctx_d.res.eq = (w_it_q.a == w_it_q.b);
      end
      default: begin
      end
    endcase
  end

  v3a_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q[63:0]),
    .root_o (root)
  );

  // Prepare divider operands: scalar for divide, magnitude otherwise
  always_comb begin
    dv_ctx_d = sq_ctx_q[SqN-1];
    is_div   = (dv_ctx_d.it.op == v3a_pkg::OP_DIV);
    if (!is_div) begin
      den = root;
    end else if (dv_ctx_d.it.s[31]) begin
      den = 32'(-dv_ctx_d.it.s);
    end else begin
      den = 32'(dv_ctx_d.it.s);
    end
    for (int i = 0; i < 3; i++) begin
      num[i] = dv_ctx_d.it.v[i][31] ? 32'(-dv_ctx_d.it.v[i]) : 32'(dv_ctx_d.it.v[i]);
    end
    if (dv_ctx_d.it.op == v3a_pkg::OP_MAG) begin
      dv_ctx_d.res.s = v3a_pkg::sat32(v3a_pkg::wide_t'(root));
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[i]),
      .den_i (den),
      .quo_o (quo[i])
    );
  end

  // Restore sign and clamp the quotients
  always_comb begin
    dv_out = dv_ctx_q[DvN-1];
    u_neg  = 1'b0;
    u_wq   = '0;
    for (int i = 0; i < 3; i++) begin
      u_neg  = dv_out.it.v[i][31] ^ ((dv_out.it.op == v3a_pkg::OP_DIV) && dv_out.it.s[31]);
      u_wq   = v3a_pkg::wide_t'(quo[i]);
      u_d[i] = v3a_pkg::sat32(u_neg ? -u_wq : u_wq);
    end
  end

  // Final selection by opcode
  always_comb begin
    res_d = '0;
    if (r2_ctx_q.it.err) begin
      res_d.err = 1'b1;
    end else begin
      case (r2_ctx_q.it.op)
        v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_SCALE, v3a_pkg::OP_EQ,
        v3a_pkg::OP_DOT, v3a_pkg::OP_CROSS, v3a_pkg::OP_MAG: begin
          res_d = r2_ctx_q.res;
        end
        v3a_pkg::OP_DIV, v3a_pkg::OP_NORM: begin
          for (int i = 0; i < 3; i++) begin
            res_d.v[i] = r2_u_q[i];
          end
        end
        v3a_pkg::OP_SRES: begin
          res_d.s = r2_sr_q;
        end
        v3a_pkg::OP_VRES: begin
          for (int i = 0; i < 3; i++) begin
            res_d.v[i] = r2_vr_q[i];
          end
        end
        v3a_pkg::OP_PERP: begin
          for (int i = 0; i < 3; i++) begin
            res_d.v[i] = v3a_pkg::sat32(v3a_pkg::wide_t'($signed(r2_ctx_q.it.a[i]))
                                      - v3a_pkg::wide_t'(r2_vr_q[i]));
          end
        end
        default: begin
          res_d.err = 1'b1;
        end
      endcase
    end
  end

  // Valid bits of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= 1'b0;
      w_vld_q   <= 1'b0;
      sq_vld_q  <= '0;
      dv_vld_q  <= '0;
      u_vld_q   <= 1'b0;
      d1_vld_q  <= 1'b0;
      d2_vld_q  <= 1'b0;
      d3_vld_q  <= 1'b0;
      r1_vld_q  <= 1'b0;
      r2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q   <= item_valid_i;
      w_vld_q   <= m_vld_q;
      sq_vld_q  <= {sq_vld_q[SqN-2:0], w_vld_q};
      dv_vld_q  <= {dv_vld_q[DvN-2:0], sq_vld_q[SqN-1]};
      u_vld_q   <= dv_vld_q[DvN-1];
      d1_vld_q  <= u_vld_q;
      d2_vld_q  <= d1_vld_q;
      d3_vld_q  <= d2_vld_q;
      r1_vld_q  <= d3_vld_q;
      r2_vld_q  <= r1_vld_q;
      out_vld_q <= r2_vld_q;
    end
  end

  // Payload of every stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_it_q <= item_i;
      for (int i = 0; i < 6; i++) begin
        m_p_q[i] <= p_d[i];
      end
      w_it_q <= m_it_q;
      sum_q  <= sum_d;
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= w_d[i];
      end
      sq_ctx_q[0] <= sq_ctx_d;
      for (int k = 1; k < SqN; k++) begin
        sq_ctx_q[k] <= sq_ctx_q[k-1];
      end
      dv_ctx_q[0] <= dv_ctx_d;
      for (int k = 1; k < DvN; k++) begin
        dv_ctx_q[k] <= dv_ctx_q[k-1];
      end
      u_ctx_q  <= dv_out;
      d1_ctx_q <= u_ctx_q;
      d2_ctx_q <= d1_ctx_q;
      d3_ctx_q <= d2_ctx_q;
      r1_ctx_q <= d3_ctx_q;
      r2_ctx_q <= r1_ctx_q;
      for (int i = 0; i < 3; i++) begin
        u_q[i]    <= u_d[i];
        d1_u_q[i] <= u_q[i];
        d1_p_q[i] <= 64'(u_ctx_q.it.a[i]) * 64'(u_q[i]);
        d2_u_q[i] <= d1_u_q[i];
        d3_u_q[i] <= d2_u_q[i];
        r1_u_q[i] <= d3_u_q[i];
        r1_p_q[i] <= 64'(d3_sr_q) * 64'(d3_u_q[i]);
        r2_u_q[i] <= r1_u_q[i];
        r2_vr_q[i] <= v3a_pkg::sat32(v3a_pkg::wide_t'(r1_p_q[i]) >>> v3a_pkg::FracBits);
      end
      d2_sum_q <= v3a_pkg::wide_t'(d1_p_q[0]) + v3a_pkg::wide_t'(d1_p_q[1])
                + v3a_pkg::wide_t'(d1_p_q[2]);
      d3_sr_q  <= v3a_pkg::sat32(d2_sum_q >>> v3a_pkg::FracBits);
      r1_sr_q  <= d3_sr_q;
      r2_sr_q  <= r1_sr_q;
      res_q    <= res_d;
    end
  end

endmodule

// File: rtl/vector3_alu.sv
// Top level of the three-dimensional vector ALU.
//
//   Channel   Handshake                 Payload
//   input     in_valid_i / in_ready_o   op_i, a_*_i, b_*_i, scalar_in_i
//   output    out_valid_o / out_ready_i r_*_o, r_scalar_o, equal_flag_o, error_flag_o
//
// One transaction per cycle is accepted and one result per cycle delivered while the
// output is not stalled. Latency from acceptance to out_valid_o is set mostly by the
// 32-stage square root and the 48-stage divider in the execution pipeline.
// rst_ni clears all valid state; the pipeline is empty after reset.
// An output stall freezes the pipeline; the four-entry queue keeps taking input until full.
`timescale 1ns / 1ps
module vector3_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] scalar_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] r_x_o,
  output logic signed [31:0] r_y_o,
  output logic signed [31:0] r_z_o,
  output logic signed [31:0] r_scalar_o,
  output logic               equal_flag_o,
  output logic               error_flag_o
);

  logic           fr_valid, fr_ready;
  v3a_pkg::item_t fr_item;
  logic           q_valid, q_ready;
  v3a_pkg::item_t q_item;
  v3a_pkg::res_t  res;

  v3a_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .a_z_i        (a_z_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .b_z_i        (b_z_i),
    .scalar_in_i  (scalar_in_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  v3a_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_item)
  );

  v3a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign r_x_o        = res.v[0];
  assign r_y_o        = res.v[1];
  assign r_z_o        = res.v[2];
  assign r_scalar_o   = res.s;
  assign equal_flag_o = res.eq;
  assign error_flag_o = res.err;

endmodule

// File: rtl/v3a_checker.sv
// Port-level checks for the vector ALU, bound to the top level.
`timescale 1ns / 1ps
module v3a_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] r_x_o,
  input logic signed [31:0] r_y_o,
  input logic signed [31:0] r_z_o,
  input logic signed [31:0] r_scalar_o,
  input logic               equal_flag_o,
  input logic               error_flag_o
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(r_x_o) && $stable(r_y_o) && $stable(r_z_o)
      && $stable(r_scalar_o) && $stable(equal_flag_o) && $stable(error_flag_o))
    else $error("result changed while stalled");

  // An error result carries nothing else
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> r_x_o == 0 && r_y_o == 0 && r_z_o == 0
      && r_scalar_o == 0 && !equal_flag_o)
    else $error("error result not cleared");

  // Equality compares only; no vector or scalar result
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && equal_flag_o |-> r_x_o == 0 && r_y_o == 0 && r_z_o == 0
      && r_scalar_o == 0)
    else $error("equality result carries data");

endmodule

bind vector3_alu v3a_checker u_v3a_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .r_x_o        (r_x_o),
  .r_y_o        (r_y_o),
  .r_z_o        (r_z_o),
  .r_scalar_o   (r_scalar_o),
  .equal_flag_o (equal_flag_o),
  .error_flag_o (error_flag_o)
);

// File: tb/vector3_alu_test.sv
// Self-checking testbench for the three-dimensional vector ALU.
`timescale 1ns / 1ps
module vector3_alu_test;

  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    logic [3:0]    op;
    v3a_pkg::vec_t a;
    v3a_pkg::vec_t b;
    v3a_pkg::fix_t s;
  } job_t;

  localparam logic [3:0] OpFirstBad = 4'd12;
  localparam int NumRandom = 450;
  localparam int IdleLimit = 3000;
  localparam int DrainCycles = 150;
  localparam v3a_pkg::fix_t FixMin = 32'sh8000_0000;
  localparam v3a_pkg::fix_t FixMax = 32'sh7fff_ffff;
  localparam v3a_pkg::fix_t FixOne = 32'sh0001_0000;
  localparam v3a_pkg::fix_t FixZero = 32'sh0000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  job_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  v3a_pkg::fix_t r_x, r_y, r_z, r_scalar;
  logic equal_flag, error_flag;

  job_t          pending_jobs[$];
  v3a_pkg::res_t expected_results[$];
  int   fails = 0;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   idle_cycles = 0;
  bit   calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  vector3_alu u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (cur.op),
    .a_x_i       (cur.a[0]),
    .a_y_i       (cur.a[1]),
    .a_z_i       (cur.a[2]),
    .b_x_i       (cur.b[0]),
    .b_y_i       (cur.b[1]),
    .b_z_i       (cur.b[2]),
    .scalar_in_i (cur.s),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .r_x_o       (r_x),
    .r_y_o       (r_y),
    .r_z_o       (r_z),
    .r_scalar_o  (r_scalar),
    .equal_flag_o(equal_flag),
    .error_flag_o(error_flag)
  );

  // Clamp an exact value to the 32-bit range
  function automatic v3a_pkg::fix_t clamp(acc_t x);
    if (x > acc_t'(FixMax)) return FixMax;
    if (x < acc_t'(FixMin)) return FixMin;
    return v3a_pkg::fix_t'(x);
  endfunction

  // Floor of the integer square root, one result bit per pass
  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] rem, res, bitv;
    rem = n;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Unsaturated fixed-point length of a vector
  function automatic acc_t length_of(v3a_pkg::vec_t v);
    acc_t sq;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += acc_t'(v[i]) * acc_t'(v[i]);
    return acc_t'({64'd0, root64(sq[63:0])});
  endfunction

  // Exact dot product scaled down with floor, then clamped
  function automatic v3a_pkg::fix_t dot_of(v3a_pkg::vec_t x, v3a_pkg::vec_t y);
    acc_t sum;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += acc_t'(x[i]) * acc_t'(y[i]);
    return clamp(sum >>> v3a_pkg::FracBits);
  endfunction

  function automatic v3a_pkg::fix_t prod_of(v3a_pkg::fix_t x, v3a_pkg::fix_t y);
    return clamp((acc_t'(x) * acc_t'(y)) >>> v3a_pkg::FracBits);
  endfunction

  // Unit vector; returns zero when the vector has no length
  function automatic bit unit_of(v3a_pkg::vec_t v, output v3a_pkg::vec_t u);
    acc_t m;
    m = length_of(v);
    u = '0;
    if (m == 0) return 1'b0;
    for (int i = 0; i < 3; i++) u[i] = clamp((acc_t'(v[i]) <<< v3a_pkg::FracBits) / m);
    return 1'b1;
  endfunction

  // Expected outputs of one transaction
  function automatic v3a_pkg::res_t alu_result(job_t j);
    v3a_pkg::res_t r;
    v3a_pkg::vec_t u;
    v3a_pkg::fix_t sr;
    acc_t t;
    r = '0;
    case (j.op)
      v3a_pkg::OP_ADD:
        for (int i = 0; i < 3; i++) r.v[i] = clamp(acc_t'(j.a[i]) + acc_t'(j.b[i]));
      v3a_pkg::OP_SUB:
        for (int i = 0; i < 3; i++) r.v[i] = clamp(acc_t'(j.a[i]) - acc_t'(j.b[i]));
      v3a_pkg::OP_SCALE:
        for (int i = 0; i < 3; i++) r.v[i] = prod_of(j.a[i], j.s);
      v3a_pkg::OP_DIV: begin
        if (j.s == 0) begin
          r.err = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++)
            r.v[i] = clamp((acc_t'(j.a[i]) <<< v3a_pkg::FracBits) / acc_t'(j.s));
        end
      end
      v3a_pkg::OP_EQ:  r.eq = (j.a == j.b);
      v3a_pkg::OP_DOT: r.s = dot_of(j.a, j.b);
      v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          t = acc_t'(j.a[(i+1)%3]) * acc_t'(j.b[(i+2)%3])
            - acc_t'(j.a[(i+2)%3]) * acc_t'(j.b[(i+1)%3]);
          r.v[i] = clamp(t >>> v3a_pkg::FracBits);
        end
      end
      v3a_pkg::OP_MAG:  r.s = clamp(length_of(j.a));
      v3a_pkg::OP_NORM: begin
        if (!unit_of(j.a, r.v)) r.err = 1'b1;
      end
      v3a_pkg::OP_SRES, v3a_pkg::OP_VRES, v3a_pkg::OP_PERP: begin
        if (!unit_of(j.b, u)) begin
          r.err = 1'b1;
        end else begin
          sr = dot_of(j.a, u);
          if (j.op == v3a_pkg::OP_SRES) begin
            r.s = sr;
          end else begin
            for (int i = 0; i < 3; i++) r.v[i] = prod_of(sr, u[i]);
            if (j.op == v3a_pkg::OP_PERP)
              for (int i = 0; i < 3; i++) r.v[i] = clamp(acc_t'(j.a[i]) - acc_t'(r.v[i]));
          end
        end
      end
      default: r.err = 1'b1;
    endcase
    return r;
  endfunction

  // Component value: mostly moderate, sometimes extreme or fully random
  function automatic v3a_pkg::fix_t pick_fix();
    case ($urandom_range(0, 9))
      0:       return FixMin;
      1:       return FixMax;
      2:       return 0;
      3, 4:    return v3a_pkg::fix_t'($urandom());
      5:       return v3a_pkg::fix_t'($urandom_range(0, 32'h0000_1fff)) - 32'sh0000_1000;
      default: return v3a_pkg::fix_t'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic job_t pick_job();
    job_t j;
    j.op = ($urandom_range(0, 19) == 0)
         ? 4'($urandom_range(OpFirstBad, 15))
         : 4'($urandom_range(v3a_pkg::OP_ADD, v3a_pkg::OP_PERP));
    for (int i = 0; i < 3; i++) begin
      j.a[i] = pick_fix();
      j.b[i] = pick_fix();
    end
    j.s = pick_fix();
    if ($urandom_range(0, 5) == 0) j.b = j.a;
    if ($urandom_range(0, 7) == 0) j.a[$urandom_range(0, 2)] = j.b[0];
    return j;
  endfunction

  function automatic int pick_wait();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // Drive input transactions from the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) expected_results.push_back(alu_result(cur));
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_jobs.size() > 0) begin
          cur <= pending_jobs.pop_front();
          in_valid <= 1'b1;
          send_wait <= pick_wait();
          if ($urandom_range(0, 39) == 0) calm = !calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result transaction and pace the output stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: v=%h %h %h s=%h eq=%b err=%b",
                   $time, r_x, r_y, r_z, r_scalar, equal_flag, error_flag);
          fails++;
        end else begin
          v3a_pkg::res_t exp_r;
          exp_r = expected_results.pop_front();
          if (exp_r.v[0] !== r_x || exp_r.v[1] !== r_y || exp_r.v[2] !== r_z ||
              exp_r.s !== r_scalar || exp_r.eq !== equal_flag || exp_r.err !== error_flag) begin
            $display("%0t: expected v=%h %h %h s=%h eq=%b err=%b", $time,
                     exp_r.v[0], exp_r.v[1], exp_r.v[2], exp_r.s, exp_r.eq, exp_r.err);
            $display("%0t: actual   v=%h %h %h s=%h eq=%b err=%b", $time,
                     r_x, r_y, r_z, r_scalar, equal_flag, error_flag);
            fails++;
          end
        end
        recv_wait = pick_wait();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("vector3_alu: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    job_t j;
    // Directed: every op on extremes, then the error and edge cases
    for (int k = v3a_pkg::OP_ADD; k <= v3a_pkg::OP_PERP; k++) begin
      j.op = 4'(k);
      j.a = {FixMin, FixMax, FixOne};
      j.b = {FixMax, FixMin, -FixOne};
      j.s = (k[0]) ? FixMin : FixMax;
      pending_jobs.push_back(j);
    end
    j = '0; j.op = v3a_pkg::OP_DIV; j.a = {FixOne, -FixOne, FixMax}; j.s = 0;
    pending_jobs.push_back(j);
    j.op = v3a_pkg::OP_EQ; j.b = j.a;
    pending_jobs.push_back(j);
    j = '0; j.op = v3a_pkg::OP_MAG;
    pending_jobs.push_back(j);
    j.op = v3a_pkg::OP_NORM;
    pending_jobs.push_back(j);
    j.a = {FixOne, FixOne, FixOne};
    for (int k = v3a_pkg::OP_SRES; k <= v3a_pkg::OP_PERP; k++) begin
      j.op = 4'(k);
      pending_jobs.push_back(j);
    end
    for (int k = OpFirstBad; k <= 15; k++) begin
      j.op = 4'(k);
      j.b = {FixOne, FixZero, FixMin};
      pending_jobs.push_back(j);
    end
    j = '0; j.op = v3a_pkg::OP_MAG; j.a = {FixMin, FixMin, FixMin};
    pending_jobs.push_back(j);
    j.op = v3a_pkg::OP_NORM;
    pending_jobs.push_back(j);
    for (int k = 0; k < NumRandom; k++) pending_jobs.push_back(pick_job());

    // Hold reset, then run until every result has come back
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_jobs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("vector3_alu: match");
    end else begin
      $display("vector3_alu: mismatch");
    end
    $finish;
  end

endmodule
